/* sv/omd_pkg.sv */
package omd_pkg;

    // Sizes of the stores and of the arithmetic.
    localparam int MAX_LEN  = 256;
    localparam int ALPHABET = 16;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int SYM_W    = $clog2(ALPHABET);
    localparam int CADDR_W  = 2 * SYM_W;
    localparam int COST_W   = 16;
    localparam int DIST_W   = 26;
    localparam int NORM_W   = 36;
    localparam int WIDE_W   = 54;
    localparam int DVD_W    = 52;
    localparam int DVS_W    = 28;
    localparam int SQ_W     = 50;
    localparam int ROOT_W   = 25;
    localparam int IT_W     = 6;

    // Operation codes of an input item.
    localparam logic [2:0] OP_WRITE_COST = 3'd0;
    localparam logic [2:0] OP_APPEND_A   = 3'd1;
    localparam logic [2:0] OP_APPEND_B   = 3'd2;
    localparam logic [2:0] OP_CLEAR      = 3'd3;
    localparam logic [2:0] OP_COMPUTE    = 3'd4;

    // Normalization modes.
    localparam logic [2:0] NM_RAW   = 3'd0;
    localparam logic [2:0] NM_LEN   = 3'd1;
    localparam logic [2:0] NM_SIM   = 3'd2;
    localparam logic [2:0] NM_MAX   = 3'd3;
    localparam logic [2:0] NM_RATIO = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_INDEL    = 2'd0;
    localparam logic [1:0] REG_NORM     = 2'd1;
    localparam logic [1:0] REG_ALPHABET = 2'd2;

    localparam logic signed [WIDE_W-1:0] ONE_Q16 = 54'sd65536;
    localparam logic signed [WIDE_W-1:0] SAT_HI  = 54'sd34359738367;
    localparam logic signed [WIDE_W-1:0] SAT_LO  = -54'sd34359738368;

    typedef struct packed {
        logic [2:0]        operation;
        logic [3:0]        symbol;
        logic [3:0]        cost_row;
        logic [3:0]        cost_col;
        logic [COST_W-1:0] cost_value;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0]        raw_distance;
        logic signed [NORM_W-1:0] normalized_distance;
    } t_result;

    typedef struct packed {
        logic [COST_W-1:0] indel_cost;
        logic [2:0]        norm_mode;
        logic [4:0]        alphabet_size;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic init_start;
        logic init_step;
        logic row_start;
        logic cell_rd;
        logic cell_cost;
        logic cell_wr;
        logic fin_rd;
        logic fin_wt;
        logic maxd;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic init_last;
        logic row_last;
        logic col_over;
        logic iter_last;
    } t_sts;

    // Clamp a wide signed value to the signed Q20.16 result range (36 bits).
    function automatic logic signed [NORM_W-1:0] sat_q16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[NORM_W-1:0];
    endfunction

endpackage

/* sv/optimal_matching_distance.sv */
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       i_item (t_item)
// result    out        o_done strobe, one cycle   o_result (t_result)
// config    in         i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data
//
// Load items (cost write, append, clear) are taken in the idle state; busy stays low.
// A compute item holds busy through a scan of the 256-entry cost table, a
// row buffer fill, three steps per cell set by the single row buffer and
// cost memory ports, then a 25-step square root and a 52-step divider. The
// result is registered, and its strobe follows the emit state.
// Reset is synchronous and active low; there is no clearing pass after it.
// Results cannot be stalled; the receiver takes each one on its strobe.
module optimal_matching_distance import omd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_item       i_item,
    output logic        busy,
    output logic        o_done,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.indel_cost    <= 16'd256;
            r_cfg.norm_mode     <= NM_RAW;
            r_cfg.alphabet_size <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_INDEL:    r_cfg.indel_cost    <= i_cfg_data;
                REG_NORM:     r_cfg.norm_mode     <= i_cfg_data[2:0];
                REG_ALPHABET: r_cfg.alphabet_size <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    omd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_item.operation),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    omd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // A result only follows a compute item in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a compute item");

    // A zero distance normalizes to zero in every mode.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.raw_distance == '0) |-> o_result.normalized_distance == '0)
        else $error("zero distance gave a nonzero normalized value");

    // Nothing is loaded while a compute item is in progress.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !cmd.load)
        else $error("load item taken while busy");

endmodule

/* sv/omd_ctrl.sv */
module omd_ctrl import omd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_op,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_END, S_INIT_START, S_INIT, S_ROW,
        S_CELL_RD, S_CELL_COST, S_CELL_WR, S_FIN_RD, S_FIN_WT,
        S_MAXD, S_SQRT, S_DIV_INIT, S_DIV, S_EMIT
    } t_state;

    t_state r_state, n_state;

    // Next state and the commands of the current state.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start && i_op == OP_COMPUTE) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_SCAN_END;
            end
            S_SCAN_END:   n_state = S_INIT_START;
            S_INIT_START: begin
                o_cmd.init_start = 1'b1;
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) n_state = S_ROW;
            end
            S_ROW: begin
                if (i_sts.row_last) begin
                    n_state = S_FIN_RD;
                end else begin
                    o_cmd.row_start = 1'b1;
                    n_state = S_CELL_RD;
                end
            end
            S_CELL_RD: begin
                if (i_sts.col_over) begin
                    n_state = S_ROW;
                end else begin
                    o_cmd.cell_rd = 1'b1;
                    n_state = S_CELL_COST;
                end
            end
            S_CELL_COST: begin
                o_cmd.cell_cost = 1'b1;
                n_state = S_CELL_WR;
            end
            S_CELL_WR: begin
                o_cmd.cell_wr = 1'b1;
                n_state = S_CELL_RD;
            end
            S_FIN_RD: begin
                o_cmd.fin_rd = 1'b1;
                n_state = S_FIN_WT;
            end
            S_FIN_WT: begin
                o_cmd.fin_wt = 1'b1;
                n_state = S_MAXD;
            end
            S_MAXD: begin
                o_cmd.maxd = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.iter_last) n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* sv/omd_dp.sv */
module omd_dp import omd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output logic    o_done,
    output t_result o_result
);

    // Stores.
    logic [SYM_W-1:0]  r_seq_a [MAX_LEN];
    logic [SYM_W-1:0]  r_seq_b [MAX_LEN];
    logic [COST_W-1:0] r_cost_mem [ALPHABET*ALPHABET];
    logic [DIST_W-1:0] r_dp [MAX_LEN+1];
    logic [ALPHABET*ALPHABET-1:0] r_cvld;

    logic [LEN_W-1:0]  r_len_a, r_len_b;

    // Scan of the cost table.
    logic [CADDR_W-1:0] r_sidx;
    logic               r_spend, r_squal;
    logic [COST_W-1:0]  r_mx, r_max_sub;

    // Recurrence.
    logic [LEN_W-1:0]  r_i, r_j;
    logic [DIST_W-1:0] r_acc, r_row0, r_left, r_diag, r_up_q;
    logic [SYM_W-1:0]  r_sa_q, r_sb_q;
    logic [COST_W-1:0] r_cost_q;
    logic              r_cost_v;

    // Normalization.
    logic [DIST_W-1:0]   r_raw;
    logic [DIST_W-2:0]   r_p1;
    logic [DIST_W-1:0]   r_p2;
    logic [2*LEN_W-1:0]  r_lalb;
    logic [DIST_W:0]     r_maxd;
    logic [SQ_W-1:0]     r_sv;
    logic [ROOT_W+1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;
    logic [DVD_W-1:0]    r_dvd;
    logic [DVS_W-1:0]    r_dvs, r_rem;
    logic                r_neg;
    logic [IT_W-1:0]     r_it;
    logic                r_out_vld;
    t_result             r_res;

    logic [CADDR_W-1:0] cost_addr;
    logic [LEN_W-1:0]   jm1, dp_waddr, dp_raddr, diff, mn, lmax;
    logic [DIST_W-1:0]  dp_wdata, cell_new;
    logic               dp_we;
    logic [DIST_W:0]    best, sub;
    logic [COST_W:0]    ind2, msub;
    logic [DIST_W:0]    mag;
    logic [ROOT_W+3:0]  sq_t, sq_trial;
    logic [DVS_W:0]     dv_t;
    logic signed [WIDE_W-1:0] q_s, norm_wide;
    logic signed [NORM_W-1:0] norm;

    assign ind2 = {i_cfg.indel_cost, 1'b0};
    assign jm1  = r_j - LEN_W'(1);
    assign cost_addr = i_cmd.cell_cost ? {r_sa_q, r_sb_q} : r_sidx;
    assign diff = (r_len_a > r_len_b) ? r_len_a - r_len_b : r_len_b - r_len_a;
    assign mn   = (r_len_a < r_len_b) ? r_len_a : r_len_b;
    assign lmax = (r_len_a > r_len_b) ? r_len_a : r_len_b;
    assign msub = (i_cfg.norm_mode == NM_RATIO) ? ind2 : {1'b0, r_max_sub};

    // One cell of the recurrence.
    always_comb begin
        best = ((r_left < r_up_q) ? {1'b0, r_left} : {1'b0, r_up_q})
               + (DIST_W+1)'(i_cfg.indel_cost);
        sub  = {1'b0, r_diag};
        if (r_sa_q != r_sb_q && r_cost_v) sub = sub + (DIST_W+1)'(r_cost_q);
        cell_new = (sub < best) ? sub[DIST_W-1:0] : best[DIST_W-1:0];
    end

    // Row buffer port selection.
    always_comb begin
        dp_we    = 1'b0;
        dp_waddr = r_j;
        dp_wdata = cell_new;
        if (i_cmd.init_step) begin
            dp_we    = 1'b1;
            dp_wdata = r_acc;
        end else if (i_cmd.row_start) begin
            dp_we    = 1'b1;
            dp_waddr = '0;
            dp_wdata = r_row0 + DIST_W'(i_cfg.indel_cost);
        end else if (i_cmd.cell_wr) begin
            dp_we = 1'b1;
        end
        dp_raddr = i_cmd.fin_rd ? r_len_b : r_j;
    end

    // Load items: lengths and cost valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
            r_cvld  <= '0;
        end else if (i_cmd.load) begin
            case (i_item.operation)
                OP_WRITE_COST: r_cvld[{i_item.cost_row, i_item.cost_col}] <= 1'b1;
                OP_APPEND_A:   if (!r_len_a[LEN_W-1]) r_len_a <= r_len_a + LEN_W'(1);
                OP_APPEND_B:   if (!r_len_b[LEN_W-1]) r_len_b <= r_len_b + LEN_W'(1);
                OP_CLEAR: begin
                    r_len_a <= '0;
                    r_len_b <= '0;
                end
                default: ;
            endcase
        end
    end

    // Symbol and cost memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_item.operation == OP_WRITE_COST)
            r_cost_mem[{i_item.cost_row, i_item.cost_col}] <= i_item.cost_value;
        if (i_cmd.load && i_item.operation == OP_APPEND_A && !r_len_a[LEN_W-1])
            r_seq_a[r_len_a[IDX_W-1:0]] <= i_item.symbol;
        if (i_cmd.load && i_item.operation == OP_APPEND_B && !r_len_b[LEN_W-1])
            r_seq_b[r_len_b[IDX_W-1:0]] <= i_item.symbol;
        r_cost_q <= r_cost_mem[cost_addr];
        r_cost_v <= r_cvld[cost_addr];
        if (i_cmd.row_start) r_sa_q <= r_seq_a[r_i[IDX_W-1:0]];
        if (i_cmd.cell_rd)   r_sb_q <= r_seq_b[jm1[IDX_W-1:0]];
    end

    // Row buffer memory.
    always_ff @(posedge i_clk) begin
        if (dp_we) r_dp[dp_waddr] <= dp_wdata;
        r_up_q <= r_dp[dp_raddr];
    end

    // Largest upper-triangle cost, capped at twice the indel cost, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spend <= 1'b0;
        end else begin
            r_spend <= i_cmd.scan_step;
        end
        if (i_cmd.scan_init) begin
            r_sidx <= '0;
            r_mx   <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_sidx  <= r_sidx + CADDR_W'(1);
                r_squal <= (r_sidx[CADDR_W-1:SYM_W] <= r_sidx[SYM_W-1:0]) &&
                           ({1'b0, r_sidx[SYM_W-1:0]} < i_cfg.alphabet_size);
            end
            if (r_spend && r_squal && r_cost_v && r_cost_q > r_mx) r_mx <= r_cost_q;
        end
        if (i_cmd.init_start)
            r_max_sub <= ({1'b0, r_mx} > ind2) ? ind2[COST_W-1:0] : r_mx;
    end

    // Row and column counters of the recurrence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_start) begin
            r_j    <= '0;
            r_i    <= '0;
            r_acc  <= '0;
            r_row0 <= '0;
        end else if (i_cmd.init_step) begin
            r_j   <= r_j + LEN_W'(1);
            r_acc <= r_acc + DIST_W'(i_cfg.indel_cost);
        end else if (i_cmd.row_start) begin
            r_diag <= r_row0;
            r_row0 <= r_row0 + DIST_W'(i_cfg.indel_cost);
            r_left <= r_row0 + DIST_W'(i_cfg.indel_cost);
            r_i    <= r_i + LEN_W'(1);
            r_j    <= LEN_W'(1);
        end else if (i_cmd.cell_wr) begin
            r_left <= cell_new;
            r_diag <= r_up_q;
            r_j    <= r_j + LEN_W'(1);
        end
    end

    // Maximum distance terms, square root and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_wt) begin
            r_raw  <= r_up_q;
            r_p1   <= (DIST_W-1)'(DIST_W'(diff) * DIST_W'(i_cfg.indel_cost));
            r_p2   <= DIST_W'(msub) * DIST_W'(mn);
            r_lalb <= r_len_a * r_len_b;
        end
        if (i_cmd.maxd) begin
            r_maxd <= {2'b00, r_p1} + {1'b0, r_p2};
            r_sv   <= SQ_W'({r_lalb, 32'b0});
            r_srem <= '0;
            r_root <= '0;
            r_it   <= IT_W'(ROOT_W - 1);
        end else if (i_cmd.sqrt_step) begin
            r_sv <= {r_sv[SQ_W-3:0], 2'b00};
            r_it <= r_it - IT_W'(1);
            if (sq_t >= sq_trial) begin
                r_srem <= (ROOT_W+2)'(sq_t - sq_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= sq_t[ROOT_W+1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end else if (i_cmd.div_init) begin
            r_neg <= {1'b0, r_raw} > r_maxd;
            r_rem <= '0;
            r_it  <= IT_W'(DVD_W - 1);
            case (i_cfg.norm_mode)
                NM_LEN: begin
                    r_dvd <= DVD_W'({r_raw, 8'b0});
                    r_dvs <= DVS_W'(lmax);
                end
                NM_SIM: begin
                    r_dvd <= DVD_W'({mag, 24'b0});
                    r_dvs <= DVS_W'({r_root, 1'b0});
                end
                NM_MAX: begin
                    r_dvd <= DVD_W'({r_raw, 16'b0});
                    r_dvs <= DVS_W'(r_maxd);
                end
                NM_RATIO: begin
                    r_dvd <= DVD_W'({r_raw, 17'b0});
                    r_dvs <= DVS_W'(r_maxd) + DVS_W'(r_raw);
                end
                default: begin
                    r_dvd <= '0;
                    r_dvs <= DVS_W'(1);
                end
            endcase
        end else if (i_cmd.div_step) begin
            r_it <= r_it - IT_W'(1);
            if (dv_t >= {1'b0, r_dvs}) begin
                r_rem <= DVS_W'(dv_t - {1'b0, r_dvs});
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= dv_t[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign mag      = ({1'b0, r_raw} > r_maxd) ? {1'b0, r_raw} - r_maxd
                                               : r_maxd - {1'b0, r_raw};
    assign sq_t     = {r_srem, r_sv[SQ_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign dv_t     = {r_rem, r_dvd[DVD_W-1]};

    // Final normalization, picked by mode.
    always_comb begin
        q_s = signed'({2'b00, r_dvd});
        case (i_cfg.norm_mode)
            NM_LEN: norm_wide = (lmax == '0) ? '0 : q_s;
            NM_SIM: begin
                if (r_len_a == '0 || r_len_b == '0)
                    norm_wide = (r_len_a != r_len_b) ? ONE_Q16 : '0;
                else
                    norm_wide = r_neg ? ONE_Q16 + q_s : ONE_Q16 - q_s;
            end
            NM_MAX:   norm_wide = (r_maxd == '0) ? ONE_Q16 : q_s;
            NM_RATIO: norm_wide = (r_maxd == '0) ? ONE_Q16 : q_s;
            default:  norm_wide = signed'(WIDE_W'({r_raw, 8'b0}));
        endcase
        norm = (r_raw == '0) ? '0 : sat_q16(norm_wide);
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_res.raw_distance        <= r_raw;
            r_res.normalized_distance <= norm;
        end
    end

    assign o_sts.scan_last = (r_sidx == '1);
    assign o_sts.init_last = (r_j == r_len_b);
    assign o_sts.row_last  = (r_i == r_len_a);
    assign o_sts.col_over  = (r_j > r_len_b);
    assign o_sts.iter_last = (r_it == '0);
    assign o_done   = r_out_vld;
    assign o_result = r_res;

endmodule

/* bench/testbench.sv */
`default_nettype none

module testbench;
    import omd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_item       i_item = '0;
    logic        busy;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_INDEL;
    logic [15:0] i_cfg_data = '0;

    optimal_matching_distance dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the block's configuration and stores.
    logic [15:0] shadow_indel = 16'd256;
    logic [2:0]  shadow_mode  = NM_RAW;
    logic [4:0]  shadow_asz   = 5'd16;
    logic [15:0] shadow_costs [0:ALPHABET*ALPHABET-1];
    logic [3:0]  shadow_seq_a [0:MAX_LEN-1];
    logic [3:0]  shadow_seq_b [0:MAX_LEN-1];
    int unsigned shadow_len_a = 0;
    int unsigned shadow_len_b = 0;

    t_result pending_distances [$];
    int      mismatches = 0;
    int      sender_idle_pct = 12;

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp_q16(longint v);
        if (v > 64'sd34359738367) return 64'sd34359738367;
        if (v < -64'sd34359738368) return -64'sd34359738368;
        return v;
    endfunction

    // Edit distance and its normalization for the current shadow state.
    function automatic t_result edit_distance();
        longint unsigned row_buf [0:MAX_LEN];
        longint unsigned indel, msub, raw, maxdist, diag, up, left, best, sub, mag, s, t;
        longint unsigned la, lb, lmax;
        longint          nrm;
        int unsigned     asz, top;
        logic [3:0]      sa, sb;
        t_result         r;
        indel = shadow_indel;
        la = shadow_len_a;
        lb = shadow_len_b;
        asz = (shadow_asz > ALPHABET) ? ALPHABET : shadow_asz;
        top = 0;
        for (int rr = 0; rr < asz; rr++)
            for (int cc = rr; cc < asz; cc++)
                if (shadow_costs[rr*ALPHABET+cc] > top) top = shadow_costs[rr*ALPHABET+cc];
        if (top > 2 * indel) top = 2 * indel;
        msub = (shadow_mode == NM_RATIO) ? 2 * indel : top;

        for (int j = 0; j <= lb; j++) row_buf[j] = j * indel;
        for (int i = 1; i <= la; i++) begin
            diag = row_buf[0];
            sa = shadow_seq_a[i-1];
            row_buf[0] = i * indel;
            for (int j = 1; j <= lb; j++) begin
                sb = shadow_seq_b[j-1];
                up = row_buf[j];
                left = row_buf[j-1];
                sub = diag;
                best = ((left < up) ? left : up) + indel;
                if (sa != sb) sub += shadow_costs[{sa, sb}];
                row_buf[j] = (sub < best) ? sub : best;
                diag = up;
            end
        end
        raw = row_buf[lb];
        maxdist = ((la > lb) ? la - lb : lb - la) * indel + msub * ((la < lb) ? la : lb);

        // Zero distance gives zero in every mode.
        if (raw == 0) begin
            nrm = 0;
        end else begin
            case (shadow_mode)
                NM_LEN: begin
                    lmax = (la > lb) ? la : lb;
                    nrm = (lmax == 0) ? 0 : clamp_q16(longint'((raw << 8) / lmax));
                end
                NM_SIM: begin
                    if (la == 0 || lb == 0) begin
                        nrm = (la != lb) ? 65536 : 0;
                    end else begin
                        s = int_sqrt((la * lb) << 32);
                        mag = (raw > maxdist) ? raw - maxdist : maxdist - raw;
                        t = (mag << 24) / (2 * s);
                        nrm = clamp_q16((raw > maxdist) ? 65536 + longint'(t)
                                                        : 65536 - longint'(t));
                    end
                end
                NM_MAX: nrm = (maxdist == 0) ? 65536
                                             : clamp_q16(longint'((raw << 16) / maxdist));
                NM_RATIO: nrm = (maxdist == 0) ? 65536
                                               : clamp_q16(longint'((raw << 17) / (raw + maxdist)));
                default: nrm = clamp_q16(longint'(raw << 8));
            endcase
        end
        r.raw_distance = raw[DIST_W-1:0];
        r.normalized_distance = nrm[NORM_W-1:0];
        return r;
    endfunction

    // Applies one accepted item to the shadow state; true when it yields a result.
    function automatic bit apply_item(t_item it);
        case (it.operation)
            OP_WRITE_COST: shadow_costs[{it.cost_row, it.cost_col}] = it.cost_value;
            OP_APPEND_A: if (shadow_len_a < MAX_LEN) begin
                shadow_seq_a[shadow_len_a] = it.symbol;
                shadow_len_a++;
            end
            OP_APPEND_B: if (shadow_len_b < MAX_LEN) begin
                shadow_seq_b[shadow_len_b] = it.symbol;
                shadow_len_b++;
            end
            OP_CLEAR: begin
                shadow_len_a = 0;
                shadow_len_b = 0;
            end
            OP_COMPUTE: return 1'b1;
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Sends one item, waits for acceptance and queues its expected result.
    task automatic send_item(t_item it, bit typed = 0, t_result typed_res = '0);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (apply_item(it)) begin
            if (typed) pending_distances.push_back(typed_res);
            else pending_distances.push_back(edit_distance());
        end
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Waits until the block is idle and every result has come.
    task automatic drain();
        start <= 1'b0;
        while (pending_distances.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_INDEL:    shadow_indel = val;
            REG_NORM:     shadow_mode  = val[2:0];
            REG_ALPHABET: shadow_asz   = val[4:0];
            default: ;
        endcase
    endtask

    function automatic t_item make_item(logic [2:0] op, logic [3:0] sym = 0,
                                        logic [3:0] row = 0, logic [3:0] col = 0,
                                        logic [15:0] val = 0);
        t_item it;
        it.operation  = op;
        it.symbol     = sym;
        it.cost_row   = row;
        it.cost_col   = col;
        it.cost_value = val;
        return it;
    endfunction

    function automatic t_result make_res(logic [25:0] raw, logic signed [35:0] nrm);
        t_result r;
        r.raw_distance = raw;
        r.normalized_distance = nrm;
        return r;
    endfunction

    // Result checker: each strobe is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_distances.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result raw=%0d norm=%0d",
                             o_result.raw_distance, o_result.normalized_distance);
            end else begin
                want = pending_distances.pop_front();
                if (o_result.raw_distance !== want.raw_distance ||
                    o_result.normalized_distance !== want.normalized_distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: raw exp %0d got %0d, norm exp %0d got %0d",
                                 want.raw_distance, o_result.raw_distance,
                                 want.normalized_distance, o_result.normalized_distance);
                end
            end
        end
    end

    // Directed stimulus table.
    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic add_row(t_item it, bit typed = 0, t_result res = '0);
        t_dir_row d;
        d.it = it;
        d.typed = typed;
        d.res = res;
        dir_rows.push_back(d);
    endtask

    // Settings the random phases step through: indel, mode, alphabet size.
    logic [15:0] phase_indel [12] = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd300, 16'd256,
                                      16'd128, 16'd0, 16'd0, 16'd512, 16'd65535, 16'd77};
    logic [15:0] phase_mode  [12] = '{NM_RAW, NM_LEN, NM_SIM, NM_MAX, NM_RATIO, 16'd7,
                                      NM_SIM, NM_SIM, NM_RATIO, NM_MAX, NM_RATIO, 16'd5};
    logic [15:0] phase_asz   [12] = '{16'd16, 16'd16, 16'd16, 16'd1, 16'd0, 16'd31,
                                      16'd5, 16'd16, 16'd16, 16'd16, 16'd16, 16'd9};

    initial begin
        t_item it;
        int    sent;
        int    na, nb;
        foreach (shadow_costs[k]) shadow_costs[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty sequences, single symbols, extreme costs and unknown operations.
        add_row(make_item(OP_COMPUTE), 1, make_res(0, 0));
        add_row(make_item(OP_APPEND_A, 4'd15));
        add_row(make_item(OP_COMPUTE), 1, make_res(256, 65536));
        add_row(make_item(OP_APPEND_B, 4'd15));
        add_row(make_item(OP_COMPUTE), 1, make_res(0, 0));
        add_row(make_item(OP_WRITE_COST, 0, 4'd15, 4'd0, 16'hFFFF));
        add_row(make_item(OP_WRITE_COST, 0, 4'd0, 4'd15, 16'hFFFF));
        add_row(make_item(OP_APPEND_B, 4'd0));
        add_row(make_item(OP_APPEND_A, 4'd0));
        add_row(make_item(OP_APPEND_A, 4'd10));
        add_row(make_item(3'd5, 4'd5, 4'd5, 4'd5, 16'h5555));
        add_row(make_item(3'd6, 4'd10, 4'd10, 4'd10, 16'hAAAA));
        add_row(make_item(3'd7, 4'd15, 4'd15, 4'd15, 16'hFFFF));
        add_row(make_item(OP_COMPUTE));
        add_row(make_item(OP_WRITE_COST, 0, 4'd10, 4'd0, 16'd1));
        add_row(make_item(OP_APPEND_B, 4'd5));
        add_row(make_item(OP_COMPUTE));
        add_row(make_item(OP_CLEAR));
        add_row(make_item(OP_COMPUTE), 1, make_res(0, 0));
        add_row(make_item(OP_APPEND_B, 4'd3));
        add_row(make_item(OP_APPEND_B, 4'd12));
        add_row(make_item(OP_COMPUTE), 1, make_res(512, 131072));
        add_row(make_item(OP_CLEAR));
        foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

        // Random phases, each under its own register setting.
        sent = 0;
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            write_reg(REG_INDEL, phase_indel[ph]);
            write_reg(REG_NORM, phase_mode[ph]);
            write_reg(REG_ALPHABET, phase_asz[ph]);
            sender_idle_pct = (ph < 4) ? 12 : (ph < 8) ? 54 : 0;

            // One full sequence A, including appends past its end.
            if (ph == 5) begin
                send_item(make_item(OP_CLEAR));
                for (int k = 0; k < MAX_LEN + 3; k++)
                    send_item(make_item(OP_APPEND_A, 4'($urandom)));
                for (int k = 0; k < 3; k++)
                    send_item(make_item(OP_APPEND_B, 4'($urandom)));
                send_item(make_item(OP_COMPUTE));
                send_item(make_item(OP_CLEAR));
                sent += MAX_LEN + 9;
            end
            // One larger square problem.
            if (ph == 9) begin
                send_item(make_item(OP_CLEAR));
                for (int k = 0; k < 40; k++) begin
                    send_item(make_item(OP_APPEND_A, 4'($urandom)));
                    send_item(make_item(OP_APPEND_B, 4'($urandom)));
                end
                send_item(make_item(OP_COMPUTE));
                sent += 82;
            end

            while (sent < (ph + 1) * 130) begin
                if ($urandom_range(9) == 0) begin
                    // Noise: any operation code with random fields.
                    it = t_item'($bits(t_item)'($urandom));
                    if (shadow_len_a + shadow_len_b > 24) it.operation = OP_CLEAR;
                    send_item(it);
                    sent++;
                end else begin
                    // A well-formed problem: usually a clear, some costs, two sequences, compute.
                    if ($urandom_range(4) != 0 || shadow_len_a + shadow_len_b > 16) begin
                        send_item(make_item(OP_CLEAR));
                        sent++;
                    end
                    repeat ($urandom_range(0, 3)) begin
                        send_item(make_item(OP_WRITE_COST, 0, 4'($urandom), 4'($urandom),
                                  ($urandom_range(7) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 1023))));
                        sent++;
                    end
                    na = $urandom_range(0, 8);
                    nb = $urandom_range(0, 8);
                    while (na + nb > 0) begin
                        if (na > 0 && (nb == 0 || $urandom_range(1))) begin
                            send_item(make_item(OP_APPEND_A, 4'($urandom_range(0, 4))
                                                ^ (4'($urandom) & 4'b1000)));
                            na--;
                        end else begin
                            send_item(make_item(OP_APPEND_B, 4'($urandom_range(0, 4))
                                                ^ (4'($urandom) & 4'b1000)));
                            nb--;
                        end
                        sent++;
                    end
                    send_item(make_item(OP_COMPUTE));
                    sent++;
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_distances.size() == 0) begin
            $display("[optimal_matching_distance] OK");
        end else begin
            $display("[optimal_matching_distance] ERROR");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #20_000_000;
        $display("[optimal_matching_distance] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
